FILE: design/dev_pkg.sv
package dev_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] SCALE_F_RST = 16'd8192;
    localparam logic [15:0] SCALE_K_RST = 16'd8192;
    localparam logic [16:0] CROSS_RATE_RST = 17'd6554;

    localparam int FRAC_W = 14;

    typedef enum logic [1:0] {
        REG_SCALE_F    = 2'd0,
        REG_SCALE_K    = 2'd1,
        REG_CROSS_RATE = 2'd2,
        REG_NONE       = 2'd3
    } dev_reg_t;

    typedef enum logic [1:0] {
        OP_RAND1 = 2'd0,
        OP_RAND2 = 2'd1,
        OP_CUR2  = 2'd2,
        OP_CUR1  = 2'd3
    } dev_op_t;

    typedef struct packed {
        logic [15:0] scale_f;
        logic [15:0] scale_k;
        logic [16:0] cross_rate;
    } dev_cfg_t;

    // per-item side data that rides along with the arithmetic
    typedef struct packed {
        logic               keep_trial;
        logic               last;
        logic signed [31:0] base;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } dev_meta_t;

    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] v,
        input logic signed [35:0] t
    );
        logic signed [36:0] s;
        logic signed [31:0] r;
        s = $signed({{5{v[31]}}, v}) + $signed({t[35], t});
        if (s[36:31] == 6'b000000 || s[36:31] == 6'b111111)
        begin
            r = s[31:0];
        end
        else if (s[36])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: design/dev_if.sv
interface dev_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] base_value;
    logic [31:0] donor_one;
    logic [31:0] donor_two;
    logic [31:0] donor_three;
    logic [31:0] donor_four;
    logic [31:0] donor_five;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic [15:0] rand_draw;
    logic        last_variable;

    modport source (
        output valid, op, base_value, donor_one, donor_two, donor_three, donor_four,
               donor_five, lower_bound, upper_bound, rand_draw, last_variable,
        input  ready
    );
    modport sink (
        input  valid, op, base_value, donor_one, donor_two, donor_three, donor_four,
               donor_five, lower_bound, upper_bound, rand_draw, last_variable,
        output ready
    );
endinterface

interface dev_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] child_value;
    logic        last_out;

    modport source (
        output valid, child_value, last_out,
        input  ready
    );
    modport sink (
        input  valid, child_value, last_out,
        output ready
    );
endinterface

FILE: design/de_variation_unit.sv
// de_variation_unit: DE mutation, bound clamp, binomial crossover and magnitude.
// Throughput: one word per cycle while dout.ready is high; each stage has a
//   valid bit of its own and stalls only when full. Stages hold the 17x33
//   multipliers and the three saturating adders.
// Reset (rst_n, async low): clears all stage valid bits and loads F and K with
//   8192 and CR with 6554.
module de_variation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dev_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dev_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dev_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    dev_in_if.sink                        din,
    dev_out_if.source                     dout
);
    import dev_pkg::*;

    dev_cfg_t           cfg;
    logic               mul_valid, mul_ready;
    logic signed [49:0] prod_a, prod_b, prod_c;
    dev_meta_t          mul_meta;
    logic               acc_valid, acc_ready;
    logic signed [31:0] acc_sum;
    dev_meta_t          acc_meta;

    dev_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dev_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .din       (din),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod_a    (prod_a),
        .prod_b    (prod_b),
        .prod_c    (prod_c),
        .out_meta  (mul_meta)
    );

    dev_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod_a    (prod_a),
        .prod_b    (prod_b),
        .prod_c    (prod_c),
        .in_meta   (mul_meta),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_sum   (acc_sum),
        .out_meta  (acc_meta)
    );

    dev_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc_valid),
        .in_ready (acc_ready),
        .in_sum   (acc_sum),
        .in_meta  (acc_meta),
        .dout     (dout)
    );

endmodule

FILE: design/dev_cfg.sv
module dev_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dev_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dev_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dev_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output dev_pkg::dev_cfg_t             cfg
);
    import dev_pkg::*;

    dev_cfg_t cfg_reg;
    dev_cfg_t cfg_next;
    dev_reg_t sel;
    logic     wr_en;

    assign sel    = dev_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_SCALE_F:    cfg_next.scale_f    = pwdata[15:0];
                REG_SCALE_K:    cfg_next.scale_k    = pwdata[15:0];
                REG_CROSS_RATE: cfg_next.cross_rate = pwdata[16:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_SCALE_F:    prdata = {16'd0, cfg_reg.scale_f};
            REG_SCALE_K:    prdata = {16'd0, cfg_reg.scale_k};
            REG_CROSS_RATE: prdata = {15'd0, cfg_reg.cross_rate};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_f    <= SCALE_F_RST;
            cfg_reg.scale_k    <= SCALE_K_RST;
            cfg_reg.cross_rate <= CROSS_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/dev_mul.sv
module dev_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  dev_pkg::dev_cfg_t  cfg,
    dev_in_if.sink             din,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [49:0] prod_a,
    output logic signed [49:0] prod_b,
    output logic signed [49:0] prod_c,
    output dev_pkg::dev_meta_t out_meta
);
    import dev_pkg::*;

    // stage 1: differences and scale selection; stage 2: products
    logic [1:0] vld_reg;
    logic [2:0] adv;

    logic signed [32:0] diff_a_reg, diff_b_reg, diff_c_reg;
    logic signed [32:0] diff_a_next, diff_b_next, diff_c_next;
    logic [15:0]        scl_a_reg, scl_b_reg, scl_c_reg;
    logic [15:0]        scl_a_next, scl_b_next, scl_c_next;
    dev_meta_t          meta1_reg, meta1_next;
    logic signed [49:0] prod_a_reg, prod_b_reg, prod_c_reg;
    logic signed [49:0] prod_a_next, prod_b_next, prod_c_next;
    dev_meta_t          meta2_reg;

    logic signed [32:0] p_x, d1_x, d2_x, d3_x, d4_x, d5_x;
    dev_op_t            op;

    assign adv[2]    = out_ready;
    assign adv[1]    = !vld_reg[1] || adv[2];
    assign adv[0]    = !vld_reg[0] || adv[1];
    assign din.ready = adv[0];
    assign out_valid = vld_reg[1];

    assign op   = dev_op_t'(din.op);
    assign p_x  = $signed({din.base_value[31], din.base_value});
    assign d1_x = $signed({din.donor_one[31], din.donor_one});
    assign d2_x = $signed({din.donor_two[31], din.donor_two});
    assign d3_x = $signed({din.donor_three[31], din.donor_three});
    assign d4_x = $signed({din.donor_four[31], din.donor_four});
    assign d5_x = $signed({din.donor_five[31], din.donor_five});

    // unused terms get a zero scale, which rounds to a zero term
    always_comb
    begin
        diff_a_next = d1_x - d2_x;
        diff_b_next = d3_x - d4_x;
        diff_c_next = '0;
        scl_a_next  = cfg.scale_f;
        scl_b_next  = '0;
        scl_c_next  = '0;
        case (op)
            OP_RAND1:
            begin
                diff_a_next = d1_x - d2_x;
            end
            OP_RAND2:
            begin
                scl_b_next = cfg.scale_f;
            end
            OP_CUR2:
            begin
                diff_a_next = p_x - d1_x;
                diff_b_next = d2_x - d3_x;
                diff_c_next = d4_x - d5_x;
                scl_a_next  = cfg.scale_k;
                scl_b_next  = cfg.scale_f;
                scl_c_next  = cfg.scale_f;
            end
            OP_CUR1:
            begin
                diff_a_next = p_x - d1_x;
                diff_b_next = d2_x - d3_x;
                scl_a_next  = cfg.scale_k;
                scl_b_next  = cfg.scale_f;
            end
            default:
            begin
                diff_a_next = d1_x - d2_x;
            end
        endcase
        meta1_next.keep_trial = din.op[1] || ({1'b0, din.rand_draw} < cfg.cross_rate);
        meta1_next.last       = din.last_variable;
        meta1_next.base       = $signed(din.base_value);
        meta1_next.lo         = $signed(din.lower_bound);
        meta1_next.hi         = $signed(din.upper_bound);
    end

    assign prod_a_next = $signed({1'b0, scl_a_reg}) * diff_a_reg;
    assign prod_b_next = $signed({1'b0, scl_b_reg}) * diff_b_reg;
    assign prod_c_next = $signed({1'b0, scl_c_reg}) * diff_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= din.valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            diff_a_reg <= diff_a_next;
            diff_b_reg <= diff_b_next;
            diff_c_reg <= diff_c_next;
            scl_a_reg  <= scl_a_next;
            scl_b_reg  <= scl_b_next;
            scl_c_reg  <= scl_c_next;
            meta1_reg  <= meta1_next;
        end
        if (adv[1])
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
            meta2_reg  <= meta1_reg;
        end
    end

    assign prod_a   = prod_a_reg;
    assign prod_b   = prod_b_reg;
    assign prod_c   = prod_c_reg;
    assign out_meta = meta2_reg;

endmodule

FILE: design/dev_acc.sv
module dev_acc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [49:0] prod_a,
    input  logic signed [49:0] prod_b,
    input  logic signed [49:0] prod_c,
    input  dev_pkg::dev_meta_t in_meta,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_sum,
    output dev_pkg::dev_meta_t out_meta
);
    import dev_pkg::*;

    // stage 3: round terms; stages 4..6: one saturating add each
    logic [3:0] vld_reg;
    logic [4:0] adv;

    localparam logic signed [49:0] HALF_LSB = 50'sd1 <<< (FRAC_W - 1);

    logic signed [49:0] rnd_a, rnd_b, rnd_c;
    logic signed [35:0] term_a_reg, term_b_reg, term_c_reg;
    logic signed [35:0] term_a_next, term_b_next, term_c_next;
    logic signed [35:0] tb4_reg, tc4_reg, tc5_reg;
    logic signed [31:0] sum4_reg, sum5_reg, sum6_reg;
    logic signed [31:0] sum4_next, sum5_next, sum6_next;
    dev_meta_t          meta3_reg, meta4_reg, meta5_reg, meta6_reg;

    always_comb
    begin
        adv[4] = out_ready;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[3];

    assign rnd_a       = prod_a + HALF_LSB;
    assign rnd_b       = prod_b + HALF_LSB;
    assign rnd_c       = prod_c + HALF_LSB;
    assign term_a_next = rnd_a[49:FRAC_W];
    assign term_b_next = rnd_b[49:FRAC_W];
    assign term_c_next = rnd_c[49:FRAC_W];

    assign sum4_next = sat_add(meta3_reg.base, term_a_reg);
    assign sum5_next = sat_add(sum4_reg, tb4_reg);
    assign sum6_next = sat_add(sum5_reg, tc5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            term_a_reg <= term_a_next;
            term_b_reg <= term_b_next;
            term_c_reg <= term_c_next;
            meta3_reg  <= in_meta;
        end
        if (adv[1])
        begin
            sum4_reg  <= sum4_next;
            tb4_reg   <= term_b_reg;
            tc4_reg   <= term_c_reg;
            meta4_reg <= meta3_reg;
        end
        if (adv[2])
        begin
            sum5_reg  <= sum5_next;
            tc5_reg   <= tc4_reg;
            meta5_reg <= meta4_reg;
        end
        if (adv[3])
        begin
            sum6_reg  <= sum6_next;
            meta6_reg <= meta5_reg;
        end
    end

    assign out_sum  = sum6_reg;
    assign out_meta = meta6_reg;

    // upstream can only be held off when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (vld_reg == 4'b1111))
        else $error("dev_acc stalled with a free stage");

endmodule

FILE: design/dev_out.sv
module dev_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in_sum,
    input  dev_pkg::dev_meta_t in_meta,
    dev_out_if.source          dout
);
    import dev_pkg::*;

    // stage 7: clamp and crossover pick; stage 8: magnitude, output word
    logic [1:0] vld_reg;
    logic [2:0] adv;

    logic signed [31:0] upper_cl;
    logic signed [31:0] clamped;
    logic signed [31:0] sel_reg, sel_next;
    logic               last7_reg;
    logic [31:0]        neg;
    logic [30:0]        mag_reg, mag_next;
    logic               last8_reg;

    assign adv[2]     = dout.ready;
    assign adv[1]     = !vld_reg[1] || adv[2];
    assign adv[0]     = !vld_reg[0] || adv[1];
    assign in_ready   = adv[0];
    assign dout.valid = vld_reg[1];

    // upper clamp first, so crossed bounds give the lower bound
    assign upper_cl = (in_sum > in_meta.hi) ? in_meta.hi : in_sum;
    assign clamped  = (upper_cl < in_meta.lo) ? in_meta.lo : upper_cl;
    assign sel_next = in_meta.keep_trial ? clamped : in_meta.base;

    // the most negative value negates to itself; saturate it
    assign neg      = sel_reg[31] ? (32'd0 - sel_reg) : sel_reg;
    assign mag_next = neg[31] ? 31'h7FFF_FFFF : neg[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sel_reg   <= sel_next;
            last7_reg <= in_meta.last;
        end
        if (adv[1])
        begin
            mag_reg   <= mag_next;
            last8_reg <= last7_reg;
        end
    end

    assign dout.child_value = mag_reg;
    assign dout.last_out    = last8_reg;

    a_trial_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (adv[0] && in_valid && in_meta.keep_trial && (in_meta.lo <= in_meta.hi))
        |=> (sel_reg >= $past(in_meta.lo)) && (sel_reg <= $past(in_meta.hi)))
        else $error("dev_out clamped trial outside bounds");

    a_parent_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (adv[0] && in_valid && !in_meta.keep_trial)
        |=> (sel_reg == $past(in_meta.base)))
        else $error("dev_out rejected trial did not take parent");

    a_hold_stage7: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !adv[1]) |=> (vld_reg[0] && $stable(sel_reg)))
        else $error("dev_out stage 7 lost its word under stall");

endmodule
